// ===== rtl/gradient_predictor_row_decode_defines.svh =====
// Assertion macros shared by the gradient predictor RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef GRADIENT_PREDICTOR_ROW_DECODE_DEFINES_SVH
`define GRADIENT_PREDICTOR_ROW_DECODE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GPR_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define GPR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/gpr_pkg.sv =====
// Types and constants for the gradient predictor row decoder.
// No dependencies; used by every module of the block.
package gpr_pkg;

    localparam int CHANNEL_BITS = 8;
    localparam int PIXEL_BITS   = 16;
    localparam int NUM_CHAN     = 3;
    localparam int SHIFT_BITS   = 4;
    localparam int WIDTH_BITS   = 12;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 12;

    typedef logic [CHANNEL_BITS-1:0]               chan_t;
    typedef logic [NUM_CHAN-1:0][CHANNEL_BITS-1:0] chan_vec_t;
    typedef logic [PIXEL_BITS-1:0]                 pixel_t;
    typedef logic [SHIFT_BITS-1:0]                 shift_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_RED_MAX     = 3'd0,
        REG_GREEN_MAX   = 3'd1,
        REG_BLUE_MAX    = 3'd2,
        REG_RED_SHIFT   = 3'd3,
        REG_GREEN_SHIFT = 3'd4,
        REG_BLUE_SHIFT  = 3'd5,
        REG_RECT_WIDTH  = 3'd6
    } cfg_reg_t;

    localparam chan_t  RED_MAX_RST     = 8'd31;
    localparam chan_t  GREEN_MAX_RST   = 8'd63;
    localparam chan_t  BLUE_MAX_RST    = 8'd31;
    localparam shift_t RED_SHIFT_RST   = 4'd11;
    localparam shift_t GREEN_SHIFT_RST = 4'd5;
    localparam shift_t BLUE_SHIFT_RST  = 4'd0;
    localparam logic [WIDTH_BITS-1:0] RECT_WIDTH_RST = 12'd1;

    typedef struct packed {
        logic [15:0] pixel_in;
        logic        start_of_rect;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  red_out;
        logic [7:0]  green_out;
        logic [7:0]  blue_out;
        logic [15:0] packed_pixel;
        logic        end_of_row;
    } out_item_t;

endpackage

// ===== rtl/gpr_line_buf.sv =====
// Line buffer holding the reconstructed channels of the previous row.
// One write and one registered read per cycle, with same-address forwarding.
// Depends on gpr_pkg.
module gpr_line_buf #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  gpr_pkg::chan_vec_t  wr_data,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output gpr_pkg::chan_vec_t  rd_data
);

    gpr_pkg::chan_vec_t mem [DEPTH];
    gpr_pkg::chan_vec_t rd_data_reg;
    gpr_pkg::chan_vec_t fwd_data_reg;
    logic               fwd_hit_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // a read that collides with this cycle's write takes the new data
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            fwd_hit_reg  <= wr_en && (wr_addr == rd_addr);
            fwd_data_reg <= wr_data;
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : rd_data_reg;

endmodule

// ===== rtl/gpr_chan.sv =====
// One colour channel: residual extract, clamped gradient prediction, mask and place.
// Depends on gpr_pkg.
module gpr_chan (
    input  gpr_pkg::pixel_t pixel,
    input  gpr_pkg::shift_t shift,
    input  gpr_pkg::chan_t  max_val,
    input  gpr_pkg::chan_t  above,
    input  gpr_pkg::chan_t  left,
    input  gpr_pkg::chan_t  upper_left,
    input  logic            col_zero,
    output gpr_pkg::chan_t  chan,
    output gpr_pkg::pixel_t placed
);

    gpr_pkg::pixel_t res;
    logic [9:0]      grad;
    gpr_pkg::chan_t  pred;

    assign res  = pixel >> shift;
    assign grad = {2'b00, above} + {2'b00, left} - {2'b00, upper_left};

    always_comb begin
        if (col_zero) begin
            pred = above;
        end else if (grad[9]) begin
            pred = '0;
        end else if (grad[8:0] > {1'b0, max_val}) begin
            pred = max_val;
        end else begin
            pred = grad[7:0];
        end
    end

    // only the low channel bits survive the mask
    assign chan   = (res[7:0] + pred) & max_val;
    assign placed = {8'h00, chan} << shift;

endmodule

// ===== rtl/gradient_predictor_row_decode.sv =====
// Gradient predictor row decoder: one 16-bit pixel in, one reconstructed pixel out.
// Pipeline: input register -> result register; an output stall holds the pixel in the input stage.
// Throughput: one pixel per cycle while m_ready is high, set by the line buffer's one read and one write port.
// Reset (aresetn low, synchronous): registers to defaults, column 0, first row set,
// pipeline empty; the line buffer is not cleared and needs no clearing pass.
`include "gradient_predictor_row_decode_defines.svh"

module gradient_predictor_row_decode #(
    parameter int MAX_ROW_WIDTH = 2048
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  gpr_pkg::in_item_t                     s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output gpr_pkg::out_item_t                    m_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [gpr_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [gpr_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    localparam int CW  = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
    localparam int WCW = CW + 1;

    // configuration
    gpr_pkg::chan_t  red_max_reg, green_max_reg, blue_max_reg;
    gpr_pkg::shift_t red_shift_reg, green_shift_reg, blue_shift_reg;
    logic [gpr_pkg::WIDTH_BITS-1:0] rect_width_reg;

    // row position
    logic [CW-1:0]  col_cnt_reg, col_cnt_next;
    logic           first_row_reg, first_row_next;
    logic [CW-1:0]  acc_col;
    logic           acc_first;
    logic           acc_last;
    logic [WCW-1:0] width_eff;
    logic [WCW-1:0] col_plus1;

    // input stage
    logic             in_valid_reg;
    gpr_pkg::pixel_t  in_pix_reg;
    logic [CW-1:0]    in_col_reg;
    logic             in_col_zero_reg;
    logic             in_first_reg;
    logic             in_last_reg;

    // neighbors
    gpr_pkg::chan_vec_t left_reg, upleft_reg;
    gpr_pkg::chan_vec_t store_rd, above, new_chan;
    gpr_pkg::pixel_t    placed [gpr_pkg::NUM_CHAN];
    gpr_pkg::chan_t     max_vec [gpr_pkg::NUM_CHAN];
    gpr_pkg::shift_t    shift_vec [gpr_pkg::NUM_CHAN];

    // result stage
    logic               m_valid_reg;
    gpr_pkg::out_item_t m_data_reg;

    logic s_fire, adv;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_max_reg     <= gpr_pkg::RED_MAX_RST;
            green_max_reg   <= gpr_pkg::GREEN_MAX_RST;
            blue_max_reg    <= gpr_pkg::BLUE_MAX_RST;
            red_shift_reg   <= gpr_pkg::RED_SHIFT_RST;
            green_shift_reg <= gpr_pkg::GREEN_SHIFT_RST;
            blue_shift_reg  <= gpr_pkg::BLUE_SHIFT_RST;
            rect_width_reg  <= gpr_pkg::RECT_WIDTH_RST;
        end else if (cfg_valid) begin
            unique case (gpr_pkg::cfg_reg_t'(cfg_index))
                gpr_pkg::REG_RED_MAX:     red_max_reg     <= cfg_data[7:0];
                gpr_pkg::REG_GREEN_MAX:   green_max_reg   <= cfg_data[7:0];
                gpr_pkg::REG_BLUE_MAX:    blue_max_reg    <= cfg_data[7:0];
                gpr_pkg::REG_RED_SHIFT:   red_shift_reg   <= cfg_data[3:0];
                gpr_pkg::REG_GREEN_SHIFT: green_shift_reg <= cfg_data[3:0];
                gpr_pkg::REG_BLUE_SHIFT:  blue_shift_reg  <= cfg_data[3:0];
                gpr_pkg::REG_RECT_WIDTH:  rect_width_reg  <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // zero width acts as one, oversize widths saturate
    always_comb begin
        if (rect_width_reg == '0) begin
            width_eff = WCW'(1);
        end else if (32'(rect_width_reg) > MAX_ROW_WIDTH) begin
            width_eff = WCW'(MAX_ROW_WIDTH);
        end else begin
            width_eff = WCW'(rect_width_reg);
        end
    end

    assign adv     = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || adv;
    assign s_fire  = s_valid && s_ready;

    assign acc_col   = s_data.start_of_rect ? '0 : col_cnt_reg;
    assign acc_first = s_data.start_of_rect ? 1'b1 : first_row_reg;
    assign col_plus1 = {1'b0, acc_col} + WCW'(1);
    assign acc_last  = (col_plus1 >= width_eff);

    assign col_cnt_next   = acc_last ? '0 : col_plus1[CW-1:0];
    assign first_row_next = acc_last ? 1'b0 : acc_first;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg   <= '0;
            first_row_reg <= 1'b1;
            in_valid_reg  <= 1'b0;
        end else begin
            if (s_fire) begin
                col_cnt_reg   <= col_cnt_next;
                first_row_reg <= first_row_next;
                in_valid_reg  <= 1'b1;
            end else if (adv) begin
                in_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_pix_reg      <= s_data.pixel_in;
            in_col_reg      <= acc_col;
            in_col_zero_reg <= (acc_col == '0);
            in_first_reg    <= acc_first;
            in_last_reg     <= acc_last;
        end
    end

    // read is issued on the transfer, write when the item leaves the input stage
    gpr_line_buf #(
        .DEPTH (MAX_ROW_WIDTH),
        .AW    (CW)
    ) u_line_buf (
        .aclk    (aclk),
        .wr_en   (adv),
        .wr_addr (in_col_reg),
        .wr_data (new_chan),
        .rd_en   (s_fire),
        .rd_addr (acc_col),
        .rd_data (store_rd)
    );

    assign above = in_first_reg ? '0 : store_rd;

    assign max_vec[0]   = red_max_reg;
    assign max_vec[1]   = green_max_reg;
    assign max_vec[2]   = blue_max_reg;
    assign shift_vec[0] = red_shift_reg;
    assign shift_vec[1] = green_shift_reg;
    assign shift_vec[2] = blue_shift_reg;

    for (genvar c = 0; c < gpr_pkg::NUM_CHAN; c++) begin : g_chan
        gpr_chan u_chan (
            .pixel      (in_pix_reg),
            .shift      (shift_vec[c]),
            .max_val    (max_vec[c]),
            .above      (above[c]),
            .left       (left_reg[c]),
            .upper_left (upleft_reg[c]),
            .col_zero   (in_col_zero_reg),
            .chan       (new_chan[c]),
            .placed     (placed[c])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg    <= '0;
            upleft_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                left_reg    <= new_chan;
                upleft_reg  <= above;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg.red_out      <= new_chan[0];
            m_data_reg.green_out    <= new_chan[1];
            m_data_reg.blue_out     <= new_chan[2];
            m_data_reg.packed_pixel <= placed[0] | placed[1] | placed[2];
            m_data_reg.end_of_row   <= in_last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `GPR_ASSERT_NEXT(a_hold_stalled, aclk, aresetn, in_valid_reg && !adv, in_valid_reg,
                     "stalled pixel dropped from input stage")
    `GPR_ASSERT_NEXT(a_adv_result, aclk, aresetn, adv, m_valid_reg,
                     "advanced pixel produced no result")
    `GPR_ASSERT_NEXT(a_last_wraps, aclk, aresetn, s_fire && acc_last,
                     col_cnt_reg == '0 && !first_row_reg, "row end did not wrap column")
    `GPR_ASSERT_NEXT(a_rect_first, aclk, aresetn, s_fire && s_data.start_of_rect,
                     in_first_reg && in_col_zero_reg, "rectangle start not taken as first row")
    `GPR_ASSERT_NOW(a_no_overrun, aclk, aresetn, s_fire, !in_valid_reg || adv,
                    "input stage overwritten")

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for gradient_predictor_row_decode: drives pixels and register
// writes, rebuilds every pixel in a local line-buffer model and checks each result.
// Depends on gpr_pkg and the RTL of the block only.
module tb;

    localparam int LINE_DEPTH    = 2048;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int WIDE_PIXELS   = 600;
    localparam int RANDOM_PIXELS = 1270;
    localparam logic [gpr_pkg::CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;

    logic                              aclk      = 1'b0;
    logic                              aresetn   = 1'b0;
    logic                              s_valid   = 1'b0;
    logic                              s_ready;
    gpr_pkg::in_item_t                 s_data    = '0;
    logic                              m_valid;
    logic                              m_ready   = 1'b0;
    gpr_pkg::out_item_t                m_data;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [gpr_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [gpr_pkg::CFG_DATA_BITS-1:0] cfg_data  = '0;

    gradient_predictor_row_decode dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Decoder state and register copies
    gpr_pkg::chan_t                 chan_max   [gpr_pkg::NUM_CHAN];
    gpr_pkg::shift_t                chan_shift [gpr_pkg::NUM_CHAN];
    logic [gpr_pkg::WIDTH_BITS-1:0] row_width;
    gpr_pkg::chan_vec_t             line_buf     [LINE_DEPTH];
    bit                             line_written [LINE_DEPTH];
    logic [10:0]                    col_count;
    bit                             first_row;
    gpr_pkg::chan_vec_t             left_px;
    gpr_pkg::chan_vec_t             upleft_px;

    gpr_pkg::out_item_t pending_q[$];
    int        errors      = 0;
    int        pixels_sent = 0;
    int        rows_ended  = 0;
    int        cfg_writes  = 0;
    int        idle_pct    = 0;
    int        stall_left  = 0;
    int        cycle_count = 0;

    function void reset_decoder_state();
        chan_max[0]   = gpr_pkg::RED_MAX_RST;
        chan_max[1]   = gpr_pkg::GREEN_MAX_RST;
        chan_max[2]   = gpr_pkg::BLUE_MAX_RST;
        chan_shift[0] = gpr_pkg::RED_SHIFT_RST;
        chan_shift[1] = gpr_pkg::GREEN_SHIFT_RST;
        chan_shift[2] = gpr_pkg::BLUE_SHIFT_RST;
        row_width     = gpr_pkg::RECT_WIDTH_RST;
        col_count     = '0;
        first_row     = 1'b1;
        left_px       = '0;
        upleft_px     = '0;
        for (int i = 0; i < LINE_DEPTH; i++) begin
            line_written[i] = 1'b0;
        end
    endfunction

    function void apply_register(input logic [gpr_pkg::CFG_IDX_BITS-1:0] idx,
                                 input logic [gpr_pkg::CFG_DATA_BITS-1:0] data);
        case (idx)
            gpr_pkg::REG_RED_MAX:     chan_max[0]   = data[7:0];
            gpr_pkg::REG_GREEN_MAX:   chan_max[1]   = data[7:0];
            gpr_pkg::REG_BLUE_MAX:    chan_max[2]   = data[7:0];
            gpr_pkg::REG_RED_SHIFT:   chan_shift[0] = data[3:0];
            gpr_pkg::REG_GREEN_SHIFT: chan_shift[1] = data[3:0];
            gpr_pkg::REG_BLUE_SHIFT:  chan_shift[2] = data[3:0];
            gpr_pkg::REG_RECT_WIDTH:  row_width     = data;
            default: ;
        endcase
    endfunction

    function int effective_width();
        if (row_width == 0) return 1;
        if (row_width > LINE_DEPTH) return LINE_DEPTH;
        return int'(row_width);
    endfunction

    // Undo the gradient filter for one pixel and advance the line state
    function automatic gpr_pkg::out_item_t reconstruct_pixel(input gpr_pkg::pixel_t px,
                                                             input logic sor);
        int                 col;
        int                 res;
        int                 pred;
        int                 v;
        logic               last;
        gpr_pkg::chan_vec_t above;
        gpr_pkg::chan_vec_t rebuilt;
        logic [63:0]        packed_acc;
        gpr_pkg::out_item_t r;
        if (sor) begin
            col_count = '0;
            first_row = 1'b1;
        end
        col        = int'(col_count);
        last       = (col + 1 >= effective_width());
        above      = first_row ? '0 : line_buf[col];
        rebuilt    = '0;
        packed_acc = '0;
        for (int c = 0; c < gpr_pkg::NUM_CHAN; c++) begin
            res = int'(px >> chan_shift[c]);
            if (col == 0) begin
                pred = int'(above[c]);
            end else begin
                pred = int'(above[c]) + int'(left_px[c]) - int'(upleft_px[c]);
                if (pred > int'(chan_max[c])) pred = int'(chan_max[c]);
                else if (pred < 0) pred = 0;
            end
            v          = (res + pred) & int'(chan_max[c]);
            rebuilt[c] = gpr_pkg::chan_t'(v);
            packed_acc = packed_acc | (64'(v) << chan_shift[c]);
        end
        line_buf[col]     = rebuilt;
        line_written[col] = 1'b1;
        left_px           = rebuilt;
        upleft_px         = above;
        if (last) begin
            col_count = '0;
            first_row = 1'b0;
        end else begin
            col_count = col_count + 11'd1;
        end
        r.red_out      = rebuilt[0];
        r.green_out    = rebuilt[1];
        r.blue_out     = rebuilt[2];
        r.packed_pixel = packed_acc[15:0];
        r.end_of_row   = last;
        return r;
    endfunction

    function automatic gpr_pkg::pixel_t random_pixel();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return gpr_pkg::pixel_t'($urandom_range(0, 31));
            default: return gpr_pkg::pixel_t'($urandom);
        endcase
    endfunction

    function automatic logic [gpr_pkg::CFG_DATA_BITS-1:0] random_max();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 12'd255;
            2: return 12'((1 << $urandom_range(1, 8)) - 1);
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    // Offer one pixel; leaves valid high so a following transfer can go back to back
    task automatic send_pixel(input gpr_pkg::pixel_t px, input logic sor);
        logic start;
        int   gap;
        start = sor;
        // never let a row read a line-buffer entry that was never written
        if (!start && !first_row && !line_written[col_count]) start = 1'b1;
        pending_q.push_back(reconstruct_pixel(px, start));
        @(negedge aclk);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            s_valid = 1'b0;
            gap = $urandom_range(1, 11);
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = '{pixel_in: px, start_of_rect: start};
        do @(posedge aclk); while (!s_ready);
        pixels_sent++;
    endtask

    // Drop valid and hold until every outstanding result has been checked
    task automatic wait_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [gpr_pkg::CFG_IDX_BITS-1:0] idx,
                                  input logic [gpr_pkg::CFG_DATA_BITS-1:0] data);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge aclk); while (!cfg_ready);
        apply_register(idx, data);
        cfg_writes++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Receiver side: random stall bursts
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready = 1'b0;
        end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            stall_left = $urandom_range(1, 11) - 1;
            m_ready = 1'b0;
        end else begin
            m_ready = 1'b1;
        end
    end

    // Compare each result transfer with the oldest expected pixel
    always @(posedge aclk) begin
        gpr_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_q.size() == 0) begin
                $error("result transfer with no pixel outstanding: packed_pixel %h",
                       m_data.packed_pixel);
                errors++;
            end else begin
                want = pending_q.pop_front();
                if (m_data.red_out !== want.red_out) begin
                    $error("red_out: expected %0d, got %0d", want.red_out, m_data.red_out);
                    errors++;
                end
                if (m_data.green_out !== want.green_out) begin
                    $error("green_out: expected %0d, got %0d",
                           want.green_out, m_data.green_out);
                    errors++;
                end
                if (m_data.blue_out !== want.blue_out) begin
                    $error("blue_out: expected %0d, got %0d", want.blue_out, m_data.blue_out);
                    errors++;
                end
                if (m_data.packed_pixel !== want.packed_pixel) begin
                    $error("packed_pixel: expected %h, got %h",
                           want.packed_pixel, m_data.packed_pixel);
                    errors++;
                end
                if (m_data.end_of_row !== want.end_of_row) begin
                    $error("end_of_row: expected %0d, got %0d",
                           want.end_of_row, m_data.end_of_row);
                    errors++;
                end
                if (want.end_of_row) rows_ended++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Reset settings: width one, so every pixel is predicted from the one above
    task automatic test_reset_settings();
        idle_pct = 20;
        send_pixel(16'hFFFF, 1'b1);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'h8421, 1'b0);
        send_pixel(16'h7BEF, 1'b1);
        send_pixel(16'hFFFF, 1'b0);
        wait_drained();
    endtask

    // Full 8-bit channels, to push predictions past both clamp limits
    task automatic test_clamp_and_mask();
        write_register(gpr_pkg::REG_RED_MAX, 12'd255);
        write_register(gpr_pkg::REG_GREEN_MAX, 12'd255);
        write_register(gpr_pkg::REG_BLUE_MAX, 12'd255);
        write_register(gpr_pkg::REG_RED_SHIFT, 12'd0);
        write_register(gpr_pkg::REG_GREEN_SHIFT, 12'd8);
        write_register(gpr_pkg::REG_BLUE_SHIFT, 12'd15);
        write_register(gpr_pkg::REG_RECT_WIDTH, 12'd3);
        send_pixel(16'hFFFF, 1'b1);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'h0001, 1'b0);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'hFF00, 1'b0);
        send_pixel(16'h00FF, 1'b0);
        wait_drained();
    endtask

    // Shrink the row while the column count is already past the new end
    task automatic test_width_lowered();
        write_register(gpr_pkg::REG_RECT_WIDTH, 12'd6);
        send_pixel(16'h1234, 1'b1);
        send_pixel(16'hABCD, 1'b0);
        send_pixel(16'h5555, 1'b0);
        send_pixel(16'hAAAA, 1'b0);
        wait_drained();
        write_register(gpr_pkg::REG_RECT_WIDTH, 12'd2);
        send_pixel(16'h0F0F, 1'b0);
        send_pixel(16'hF0F0, 1'b0);
        send_pixel(16'h8001, 1'b0);
        wait_drained();
    endtask

    // Width zero, zero mask, wide data words, top shifts and an unmapped index
    task automatic test_degenerate_settings();
        write_register(gpr_pkg::REG_RED_MAX, 12'd0);
        write_register(gpr_pkg::REG_GREEN_MAX, 12'hFFF);
        write_register(gpr_pkg::REG_BLUE_MAX, 12'd1);
        write_register(gpr_pkg::REG_RED_SHIFT, 12'hFFF);
        write_register(gpr_pkg::REG_GREEN_SHIFT, 12'd15);
        write_register(gpr_pkg::REG_BLUE_SHIFT, 12'd14);
        write_register(gpr_pkg::REG_RECT_WIDTH, 12'd0);
        write_register(REG_UNUSED, 12'hFFF);
        send_pixel(16'hFFFF, 1'b1);
        send_pixel(16'h8000, 1'b0);
        send_pixel(16'h7FFF, 1'b0);
        send_pixel(16'hC000, 1'b1);
        wait_drained();
    endtask

    // Oversized width saturates to the line-buffer depth: a long first row with no early end
    task automatic test_widest_row();
        idle_pct = 10;
        write_register(gpr_pkg::REG_RED_MAX, 12'd255);
        write_register(gpr_pkg::REG_GREEN_MAX, 12'd63);
        write_register(gpr_pkg::REG_BLUE_MAX, 12'd31);
        write_register(gpr_pkg::REG_RED_SHIFT, 12'd8);
        write_register(gpr_pkg::REG_GREEN_SHIFT, 12'd3);
        write_register(gpr_pkg::REG_BLUE_SHIFT, 12'd0);
        write_register(gpr_pkg::REG_RECT_WIDTH, 12'hFFF);
        for (int i = 0; i < WIDE_PIXELS; i++) begin
            send_pixel(random_pixel(), i == 0);
        end
        wait_drained();
    endtask

    // Rectangles under random settings; a few stray start flags break rows apart
    task automatic test_random_rects();
        int  sent;
        int  rows;
        int  cols;
        bit  fresh;
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            if (sent > RANDOM_PIXELS * 85 / 100) begin
                idle_pct = 0;
            end else begin
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 10;
                    default: idle_pct = 30;
                endcase
            end
            if ($urandom_range(0, 4) < 3) write_register(gpr_pkg::REG_RED_MAX, random_max());
            if ($urandom_range(0, 4) < 3) write_register(gpr_pkg::REG_GREEN_MAX, random_max());
            if ($urandom_range(0, 4) < 3) write_register(gpr_pkg::REG_BLUE_MAX, random_max());
            if ($urandom_range(0, 4) < 3)
                write_register(gpr_pkg::REG_RED_SHIFT, 12'($urandom_range(0, 4095)));
            if ($urandom_range(0, 4) < 3)
                write_register(gpr_pkg::REG_GREEN_SHIFT, 12'($urandom_range(0, 15)));
            if ($urandom_range(0, 4) < 3)
                write_register(gpr_pkg::REG_BLUE_SHIFT, 12'($urandom_range(0, 15)));
            if ($urandom_range(0, 4) < 3) begin
                case ($urandom_range(0, 9))
                    0: write_register(gpr_pkg::REG_RECT_WIDTH, 12'd0);
                    1: write_register(gpr_pkg::REG_RECT_WIDTH, 12'($urandom_range(13, 80)));
                    default: write_register(gpr_pkg::REG_RECT_WIDTH,
                                            12'($urandom_range(1, 12)));
                endcase
            end
            fresh = ($urandom_range(0, 3) != 0);
            rows  = $urandom_range(1, 6);
            cols  = effective_width();
            for (int r = 0; r < rows; r++) begin
                for (int c = 0; c < cols; c++) begin
                    send_pixel(random_pixel(),
                               (r == 0 && c == 0 && fresh) || $urandom_range(0, 59) == 0);
                    sent++;
                end
            end
            wait_drained();
        end
    endtask

    initial begin
        reset_decoder_state();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_settings();
        test_clamp_and_mask();
        test_width_lowered();
        test_degenerate_settings();
        test_widest_row();
        test_random_rects();
        wait_drained();

        $display("Decoded %0d pixels ending %0d rows, with %0d register writes.",
                 pixels_sent, rows_ended, cfg_writes);
        $display("Covered reset settings, clamp limits, zero and oversized widths, %s",
                 "a shortened row and random rectangles under stalls.");
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
